[rtl/core/psu_pkg.sv]
// Shared types, constants and pixel decode functions for the planar screen
// pixel unpacker. No dependencies; every other file of the block imports it.
`default_nettype none

package psu_pkg;

  // Widest row the column counter tracks
  localparam int MAX_WIDTH = 320;
  localparam int ROW_W     = 9;
  localparam int COL_W     = $clog2(MAX_WIDTH + 1);
  localparam int LIM_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int IDX_W     = 4;
  localparam int KEPT_W    = IDX_W + 1;

  localparam logic [ROW_W-1:0] ROW_WIDTH_RST = ROW_W'(320);

  // Group modes
  localparam logic [1:0] MODE_ATTR   = 2'd0;
  localparam logic [1:0] MODE_PLANE16 = 2'd1;
  localparam logic [1:0] MODE_PLANE8 = 2'd2;
  localparam logic [1:0] MODE_PACKED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] plane0;
    logic [15:0] plane1;
    logic [15:0] plane2;
    logic [15:0] plane3;
    logic [7:0]  attribute;
    logic        row_start;
  } psu_in_t;

  typedef struct packed {
    logic [3:0] color_index;
    logic       last;
  } psu_out_t;

  // One classified group waiting for the serializer
  typedef struct packed {
    logic [1:0]        mode;
    logic [15:0]       plane0;
    logic [15:0]       plane1;
    logic [15:0]       plane2;
    logic [15:0]       plane3;
    logic [6:0]        attribute;
    logic [KEPT_W-1:0] kept;
  } psu_entry_t;

  typedef struct packed {
    logic       valid;
    psu_entry_t entry;
  } psu_slot_t;

  function automatic logic [KEPT_W-1:0] group_size(input logic [1:0] mode);
    logic [KEPT_W-1:0] n;
    case (mode)
      MODE_PLANE16: n = KEPT_W'(16);
      MODE_PACKED:  n = KEPT_W'(4);
      default:      n = KEPT_W'(8);
    endcase
    return n;
  endfunction

  // Color of pixel idx of a group, leftmost pixel first
  function automatic logic [3:0] pixel_color(input psu_entry_t e,
                                             input logic [IDX_W-1:0] idx);
    logic [3:0] pos16;
    logic [2:0] pos8;
    logic [1:0] pos4;
    logic [3:0] c;
    pos16 = ~idx;
    pos8  = ~idx[2:0];
    pos4  = ~idx[1:0];
    case (e.mode)
      MODE_ATTR: begin
        c = e.plane0[pos8] ? {e.attribute[6], e.attribute[2:0]}
                           : {e.attribute[6], e.attribute[5:3]};
      end
      MODE_PLANE16: begin
        c = {e.plane3[pos16], e.plane2[pos16], e.plane1[pos16], e.plane0[pos16]};
      end
      MODE_PLANE8: begin
        c = {e.plane3[pos8], e.plane2[pos8], e.plane1[pos8], e.plane0[pos8]};
      end
      MODE_PACKED: begin
        c = {2'b00, e.plane0[{pos4, 1'b1}], e.plane0[{pos4, 1'b0}]};
      end
      default: c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/psu_front.sv]
// Front end: takes input words, tracks the row column, clips each group to the
// kept width and pushes groups with pixels left into the queue. Uses psu_pkg.
`default_nettype none

module psu_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire psu_pkg::psu_in_t        in_data,
  input  wire logic                    cfg_wr_en,
  input  wire logic [psu_pkg::ROW_W-1:0] cfg_wr_data,
  input  wire logic                    q_full,
  output psu_pkg::psu_slot_t           push
);
  import psu_pkg::*;

  logic [ROW_W-1:0]  row_width_r, row_width_nxt;
  logic [COL_W-1:0]  column_r, column_nxt;
  logic              accept;
  logic [COL_W-1:0]  col0;
  logic [KEPT_W-1:0] count;
  logic [LIM_W-1:0]  limit, rem;
  logic [KEPT_W-1:0] kept;
  logic [COL_W:0]    col_sum;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  always_comb begin
    col0  = in_data.row_start ? '0 : column_r;
    count = group_size(in_data.mode);
    limit = (LIM_W'(row_width_r) < LIM_W'(MAX_WIDTH)) ? LIM_W'(row_width_r)
                                                       : LIM_W'(MAX_WIDTH);
    rem   = (LIM_W'(col0) < limit) ? (limit - LIM_W'(col0)) : '0;
    kept  = (rem < LIM_W'(count)) ? KEPT_W'(rem) : count;
    // column saturates at the widest row
    col_sum = {1'b0, col0} + (COL_W+1)'(count);
  end

  always_comb begin
    row_width_nxt = cfg_wr_en ? cfg_wr_data : row_width_r;
    column_nxt    = column_r;
    if (accept) begin
      column_nxt = (col_sum > (COL_W+1)'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH)
                                                      : col_sum[COL_W-1:0];
    end
  end

  always_comb begin
    push.valid           = accept & (kept != '0);
    push.entry.mode      = in_data.mode;
    push.entry.plane0    = in_data.plane0;
    push.entry.plane1    = in_data.plane1;
    push.entry.plane2    = in_data.plane2;
    push.entry.plane3    = in_data.plane3;
    push.entry.attribute = in_data.attribute[6:0];
    push.entry.kept      = kept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      column_r    <= '0;
    end else begin
      row_width_r <= row_width_nxt;
      column_r    <= column_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/psu_queue.sv]
// Two-entry queue of classified groups between front end and serializer.
// Uses psu_pkg for the entry type.
`default_nettype none

module psu_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire psu_pkg::psu_slot_t push,
  input  wire logic               pop,
  output psu_pkg::psu_slot_t      head,
  output logic                    full
);
  import psu_pkg::*;

  psu_entry_t  e0_r, e0_nxt, e1_r, e1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.entry = e0_r;

  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r;
    if (push.valid && pop) begin
      if (cnt_r == 2'd1) begin
        e0_nxt = push.entry;
      end else begin
        e0_nxt = e1_r;
        e1_nxt = push.entry;
      end
    end else if (pop) begin
      e0_nxt  = e1_r;
      cnt_nxt = cnt_r - 2'd1;
    end else if (push.valid) begin
      if (cnt_r == 2'd0) begin
        e0_nxt = push.entry;
      end else begin
        e1_nxt = push.entry;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/psu_back.sv]
// Back end: takes one group from the queue and shifts out its kept pixels,
// one per cycle unless the output stalls, through an output register. Uses psu_pkg.
`default_nettype none

module psu_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire psu_pkg::psu_slot_t head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output psu_pkg::psu_out_t       out_data
);
  import psu_pkg::*;

  logic             cur_valid_r, cur_valid_nxt;
  psu_entry_t       cur_r, cur_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  psu_out_t         out_data_r, out_data_nxt;
  logic             emit;
  logic             is_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign emit    = cur_valid_r & (~out_valid_r | ~out_stall);
  assign is_last = (({1'b0, idx_r} + KEPT_W'(1)) == cur_r.kept);
  // load the next group in the cycle the last pixel leaves
  assign pop     = head.valid & (~cur_valid_r | (emit & is_last));

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = head.entry;
      idx_nxt       = '0;
    end else if (emit && is_last) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.color_index = pixel_color(cur_r, idx_r);
      out_data_nxt.last        = is_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/planar_screen_pixel_unpacker.sv]
// Top level of the planar screen pixel unpacker: front end, two-entry queue
// and pixel serializer. Uses psu_pkg, psu_front, psu_queue and psu_back.
`default_nettype none

// Each input word is one pixel group (attribute bitmap: 8 pixels, interleaved
// 16-bit planes: 16, byte planes: 8, two-bit packed: 4). The block emits one
// 4-bit color index per kept pixel, leftmost first, with last set on the
// final kept pixel of the group. Pixels at or past min(row_width, 320) in the
// current row are dropped; a group with none left gives no output at all.
// Output runs at one pixel per cycle while out_stall is low, and a group holds
// the serializer until all its kept pixels (1 to 16) have left; input words
// are taken every cycle while the two-entry queue in front of the serializer
// has room. Write row_width only while the block is idle.
module planar_screen_pixel_unpacker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire psu_pkg::psu_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output psu_pkg::psu_out_t              out_data,
  input  wire logic                      cfg_wr_en,
  input  wire logic [psu_pkg::ROW_W-1:0] cfg_wr_data
);
  import psu_pkg::*;

  psu_slot_t push;
  psu_slot_t head;
  logic      pop;
  logic      q_full;

  psu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_full     (q_full),
    .push       (push)
  );

  psu_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  psu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !q_full)
    else $error("push into full queue");

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid |-> (head.entry.kept != '0) && (head.entry.kept <= KEPT_W'(16)))
    else $error("queued group with bad kept count");
`endif

endmodule

`default_nettype wire

[tb/planar_screen_pixel_unpacker_tb.sv]
// Self-checking testbench for planar_screen_pixel_unpacker: random bursty groups in,
// stalled pixel stream out, each pixel checked against an in-bench pixel predictor.
// Depends on psu_pkg and the block's RTL only.
module planar_screen_pixel_unpacker_tb;
  import psu_pkg::*;

  localparam int SETTLE_CYCLES = 64;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  psu_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  psu_out_t         out_data;
  logic             cfg_wr_en = 1'b0;
  logic [ROW_W-1:0] cfg_wr_data = '0;

  planar_screen_pixel_unpacker uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  psu_in_t          groups_to_send[$];
  psu_out_t         pixels_due[$];
  logic [ROW_W-1:0] kept_width = ROW_WIDTH_RST;
  int               row_column = 0;
  int               fail_count = 0;
  logic             in_taken = 1'b0;
  int               burst_left = 1;
  int               gap_left = 0;
  logic [8:0]       stall_cyc = '0;
  int               gen_col;
  int               gen_row_len;

  function automatic int group_pixels(input logic [1:0] mode);
    case (mode)
      MODE_PLANE16: return 16;
      MODE_PACKED:  return 4;
      default:      return 8;
    endcase
  endfunction

  // Expand one group into the pixels that survive the row width clip
  task automatic predict_pixels(input psu_in_t w);
    psu_out_t   kept[16];
    int         n;
    int         limit;
    int         pos;
    logic [3:0] color;
    logic [3:0] ink;
    logic [3:0] paper;
    logic [15:0] sh;
    n = 0;
    limit = (int'(kept_width) < MAX_WIDTH) ? int'(kept_width) : MAX_WIDTH;
    if (w.row_start) row_column = 0;
    ink   = {w.attribute[6], w.attribute[2:0]};
    paper = {w.attribute[6], w.attribute[5:3]};
    for (int i = 0; i < group_pixels(w.mode); i++) begin
      case (w.mode)
        MODE_ATTR: begin
          color = w.plane0[7 - i] ? ink : paper;
        end
        MODE_PLANE16: begin
          pos = 15 - i;
          color = {w.plane3[pos], w.plane2[pos], w.plane1[pos], w.plane0[pos]};
        end
        MODE_PLANE8: begin
          pos = 7 - i;
          color = {w.plane3[pos], w.plane2[pos], w.plane1[pos], w.plane0[pos]};
        end
        default: begin
          sh = w.plane0 >> (6 - 2 * i);
          color = {2'b00, sh[1:0]};
        end
      endcase
      if (row_column < limit) begin
        kept[n].color_index = color;
        kept[n].last = 1'b0;
        n++;
      end
      // Saturate at the widest row until the next row start
      if (row_column < MAX_WIDTH) row_column++;
    end
    if (n > 0) kept[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) pixels_due.push_back(kept[i]);
  endtask

  // Sender: bursts of words with random gaps in between
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled word
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (groups_to_send.size() > 0) begin
      in_valid <= 1'b1;
      in_data <= groups_to_send.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: cycle through free flow, random, periodic and heavy stalling
  always @(negedge clk) begin
    stall_cyc <= stall_cyc + 1'b1;
    case (stall_cyc[8:7])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 2) == 0);
      2'd2:    out_stall <= (stall_cyc[2:0] < 3'd3);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Predict on each accepted group first, then check any accepted pixel
  always @(posedge clk) begin
    psu_out_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_pixels(in_data);
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel: color_index %0d last %0b",
                 out_data.color_index, out_data.last);
          fail_count++;
        end else begin
          want = pixels_due.pop_front();
          if (out_data.color_index !== want.color_index) begin
            $error("color_index: expected %0d, got %0d",
                   want.color_index, out_data.color_index);
            fail_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (!(groups_to_send.size() == 0 && (!in_valid || in_taken) &&
             pixels_due.size() == 0));
  endtask

  // Let clipped groups still in flight pass before touching the register
  task automatic set_row_width(input logic [ROW_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    kept_width = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    gen_col = 1 << 20;
  endtask

  task automatic push_group(input logic [1:0] mode, input logic [15:0] p0,
                            input logic [15:0] p1, input logic [15:0] p2,
                            input logic [15:0] p3, input logic [7:0] attr,
                            input logic rs);
    psu_in_t w;
    w.mode = mode;
    w.plane0 = p0;
    w.plane1 = p1;
    w.plane2 = p2;
    w.plane3 = p3;
    w.attribute = attr;
    w.row_start = rs;
    groups_to_send.push_back(w);
  endtask

  // Mostly well-formed rows that run a little past the kept width, plus noise
  task automatic queue_random(input int n);
    psu_in_t w;
    int      limit;
    limit = (int'(kept_width) < MAX_WIDTH) ? int'(kept_width) : MAX_WIDTH;
    @(posedge clk);
    for (int k = 0; k < n; k++) begin
      w.mode = 2'($urandom_range(0, 3));
      w.plane0 = 16'($urandom);
      w.plane1 = 16'($urandom);
      w.plane2 = 16'($urandom);
      w.plane3 = 16'($urandom);
      w.attribute = 8'($urandom);
      w.row_start = (gen_col >= gen_row_len);
      if ($urandom_range(0, 19) == 0) w.row_start = ~w.row_start;
      if (w.row_start) begin
        gen_col = 0;
        gen_row_len = limit + $urandom_range(0, 24);
      end
      gen_col += group_pixels(w.mode);
      groups_to_send.push_back(w);
    end
  endtask

  initial begin
    gen_col = 1 << 20;
    gen_row_len = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed groups at the reset row width
    @(posedge clk);
    push_group(MODE_ATTR, 16'h00A5, 16'h0000, 16'h0000, 16'h0000, 8'h47, 1'b1);
    push_group(MODE_ATTR, 16'h5A3C, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hB8, 1'b0);
    push_group(MODE_ATTR, 16'hFFFF, 16'h1234, 16'h5678, 16'h9ABC, 8'h00, 1'b0);
    push_group(MODE_ATTR, 16'hFF00, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 1'b0);
    push_group(MODE_ATTR, 16'h0081, 16'h0000, 16'h0000, 16'h0000, 8'h7F, 1'b0);
    push_group(MODE_PLANE16, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 1'b0);
    push_group(MODE_PLANE16, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0);
    push_group(MODE_PLANE16, 16'h8001, 16'h4002, 16'h2004, 16'h1008, 8'h00, 1'b0);
    push_group(MODE_PLANE8, 16'hFF80, 16'hFF40, 16'hFF20, 16'hFF10, 8'hFF, 1'b0);
    push_group(MODE_PLANE8, 16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 8'h00, 1'b0);
    push_group(MODE_PLANE8, 16'hAA00, 16'h5501, 16'h0F02, 16'hF003, 8'h00, 1'b0);
    push_group(MODE_PACKED, 16'hFF1B, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
    push_group(MODE_PACKED, 16'h00E4, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    push_group(MODE_PACKED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    push_group(MODE_PACKED, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1);
    queue_random(20);

    set_row_width(9'd1);
    queue_random(12);
    set_row_width(9'd0);
    queue_random(8);
    set_row_width(9'd511);
    queue_random(25);

    // One long row: the column must saturate rather than wrap
    set_row_width(9'd13);
    @(posedge clk);
    for (int k = 0; k < 36; k++)
      push_group(MODE_PLANE16, 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 8'($urandom), k == 0);
    queue_random(10);

    set_row_width(9'($urandom_range(2, 319)));
    queue_random(12);
    // Pause the sender until every pixel has come out
    wait_drained();
    queue_random(10);
    set_row_width(9'd320);
    queue_random(6);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/psu_pkg.sv
rtl/core/psu_front.sv
rtl/core/psu_queue.sv
rtl/core/psu_back.sv
rtl/core/planar_screen_pixel_unpacker.sv
tb/planar_screen_pixel_unpacker_tb.sv
